// ===== sv/bmp24sp_pkg.sv =====
package bmp24sp_pkg;

  localparam int unsigned MAX_DIMENSION_DEF = 4096;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_DEPTH     = 16'd24;
  localparam logic [31:0] HEADER_END    = 32'd30;

  // fixed header byte positions
  localparam logic [31:0] POS_SIG_LO    = 32'd0;
  localparam logic [31:0] POS_SIG_HI    = 32'd1;
  localparam logic [31:0] POS_OFFSET_LO = 32'd10;
  localparam logic [31:0] POS_OFFSET_HI = 32'd13;
  localparam logic [31:0] POS_WIDTH_LO  = 32'd18;
  localparam logic [31:0] POS_WIDTH_HI  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_LO = 32'd22;
  localparam logic [31:0] POS_HEIGHT_HI = 32'd25;
  localparam logic [31:0] POS_DEPTH_LO  = 32'd28;
  localparam logic [31:0] POS_DEPTH_HI  = 32'd29;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_BAD_SIG,
    ST_BAD_DEPTH,
    ST_BAD_SIZE
  } status_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] row_index;
    logic [11:0] column_index;
    logic        last_pixel;
    status_e     status;
  } result_t;

endpackage

// ===== sv/bmp24sp_core.sv =====
module bmp24sp_core #(
  parameter int unsigned MAX_DIMENSION = bmp24sp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_of_file_i,
  output bmp24sp_pkg::result_t  result_o
);

  localparam int unsigned CntW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int unsigned ExtW = CntW + 12;
  localparam logic [31:0] MaxDim = 32'(MAX_DIMENSION);

  bmp24sp_pkg::phase_e phase_q, phase_d, phase_c;
  logic [31:0]         pos_q, pos_d, pos_c;
  logic [31:0]         offset_q, offset_d, offset_c;
  logic [31:0]         width_q, width_d, width_c;
  logic [31:0]         height_q, height_d, height_c;
  logic [15:0]         scratch_q, scratch_d, scratch_c;
  logic [7:0]          blue_q, blue_d;
  logic [7:0]          green_q, green_d;
  logic [1:0]          bip_q, bip_d;
  logic [CntW-1:0]     col_q, col_d;
  logic [CntW-1:0]     row_q, row_d;
  logic [1:0]          pad_q, pad_d;

  logic [15:0]         hi_word;
  logic                sig_bad;
  logic                depth_bad;
  logic                size_bad;
  logic [31:0]         pos_inc;
  logic [1:0]          lane;
  logic [CntW:0]       col_inc;
  logic [CntW:0]       row_inc;
  logic                last_col;
  logic                last_row;
  logic                pixel_done;
  logic [ExtW-1:0]     row_ext;
  logic [ExtW-1:0]     col_ext;

  // a start beat abandons the current parse and counts as byte 0
  always_comb begin
    if (start_of_file_i) begin
      phase_c   = bmp24sp_pkg::PH_HEADER;
      pos_c     = '0;
      offset_c  = '0;
      width_c   = '0;
      height_c  = '0;
      scratch_c = '0;
    end else begin
      phase_c   = phase_q;
      pos_c     = pos_q;
      offset_c  = offset_q;
      width_c   = width_q;
      height_c  = height_q;
      scratch_c = scratch_q;
    end
  end

  assign hi_word   = {data_byte_i, scratch_c[7:0]};
  assign sig_bad   = (hi_word != bmp24sp_pkg::BMP_SIGNATURE);
  assign depth_bad = (hi_word != bmp24sp_pkg::BMP_DEPTH);
  assign size_bad  = (width_c == '0) || (width_c > MaxDim) ||
                     (height_c == '0) || (height_c > MaxDim) ||
                     (offset_c < bmp24sp_pkg::HEADER_END);
  assign pos_inc   = pos_c + 32'd1;
  // offset, width and height fields all start on a position with low bits 2'b10
  assign lane      = pos_c[1:0] - 2'd2;

  assign col_inc    = {1'b0, col_q} + 1'b1;
  assign row_inc    = {1'b0, row_q} + 1'b1;
  assign last_col   = (col_inc == width_c[CntW:0]);
  assign last_row   = (row_inc == height_c[CntW:0]);
  assign pixel_done = (pad_q == 2'd0) && (bip_q == 2'd2);
  assign row_ext    = ExtW'(row_q);
  assign col_ext    = ExtW'(col_q);

  // next phase
  always_comb begin
    phase_d = phase_c;
    unique case (phase_c)
      bmp24sp_pkg::PH_HEADER: begin
        if (pos_c == bmp24sp_pkg::POS_SIG_HI && sig_bad) begin
          phase_d = bmp24sp_pkg::PH_ERROR;
        end else if (pos_c == bmp24sp_pkg::POS_DEPTH_HI) begin
          if (depth_bad || size_bad) begin
            phase_d = bmp24sp_pkg::PH_ERROR;
          end else if (offset_c == bmp24sp_pkg::HEADER_END) begin
            phase_d = bmp24sp_pkg::PH_PIXELS;
          end else begin
            phase_d = bmp24sp_pkg::PH_SKIP;
          end
        end
      end
      bmp24sp_pkg::PH_SKIP: begin
        if (pos_inc == offset_c) begin
          phase_d = bmp24sp_pkg::PH_PIXELS;
        end
      end
      bmp24sp_pkg::PH_PIXELS: begin
        if (pixel_done && last_col && last_row) begin
          phase_d = bmp24sp_pkg::PH_DONE;
        end
      end
      default: phase_d = phase_c;
    endcase
  end

  // datapath and result
  always_comb begin
    pos_d     = pos_c;
    offset_d  = offset_c;
    width_d   = width_c;
    height_d  = height_c;
    scratch_d = scratch_c;
    blue_d    = blue_q;
    green_d   = green_q;
    bip_d     = bip_q;
    col_d     = col_q;
    row_d     = row_q;
    pad_d     = pad_q;
    result_o  = '0;
    unique case (phase_c)
      bmp24sp_pkg::PH_HEADER: begin
        pos_d = pos_inc;
        if (pos_c == bmp24sp_pkg::POS_SIG_LO || pos_c == bmp24sp_pkg::POS_DEPTH_LO) begin
          scratch_d = {8'h00, data_byte_i};
        end else if (pos_c == bmp24sp_pkg::POS_SIG_HI) begin
          scratch_d = hi_word;
          if (sig_bad) begin
            result_o.valid  = 1'b1;
            result_o.status = bmp24sp_pkg::ST_BAD_SIG;
          end
        end else if (pos_c >= bmp24sp_pkg::POS_OFFSET_LO &&
                     pos_c <= bmp24sp_pkg::POS_OFFSET_HI) begin
          offset_d[{lane, 3'b000} +: 8] = data_byte_i;
        end else if (pos_c >= bmp24sp_pkg::POS_WIDTH_LO &&
                     pos_c <= bmp24sp_pkg::POS_WIDTH_HI) begin
          width_d[{lane, 3'b000} +: 8] = data_byte_i;
        end else if (pos_c >= bmp24sp_pkg::POS_HEIGHT_LO &&
                     pos_c <= bmp24sp_pkg::POS_HEIGHT_HI) begin
          height_d[{lane, 3'b000} +: 8] = data_byte_i;
        end else if (pos_c == bmp24sp_pkg::POS_DEPTH_HI) begin
          scratch_d = hi_word;
          if (depth_bad) begin
            result_o.valid  = 1'b1;
            result_o.status = bmp24sp_pkg::ST_BAD_DEPTH;
          end else if (size_bad) begin
            result_o.valid  = 1'b1;
            result_o.status = bmp24sp_pkg::ST_BAD_SIZE;
          end else begin
            bip_d = 2'd0;
            col_d = '0;
            row_d = '0;
            pad_d = 2'd0;
          end
        end
      end
      bmp24sp_pkg::PH_SKIP: begin
        pos_d = pos_inc;
        if (pos_inc == offset_c) begin
          bip_d = 2'd0;
          col_d = '0;
          row_d = '0;
          pad_d = 2'd0;
        end
      end
      bmp24sp_pkg::PH_PIXELS: begin
        if (pad_q != 2'd0) begin
          pad_d = pad_q - 2'd1;
        end else if (bip_q == 2'd0) begin
          blue_d = data_byte_i;
          bip_d  = 2'd1;
        end else if (bip_q == 2'd1) begin
          green_d = data_byte_i;
          bip_d   = 2'd2;
        end else begin
          bip_d                 = 2'd0;
          result_o.valid        = 1'b1;
          result_o.blue         = blue_q;
          result_o.green        = green_q;
          result_o.red          = data_byte_i;
          result_o.row_index    = row_ext[11:0];
          result_o.column_index = col_ext[11:0];
          result_o.last_pixel   = last_col && last_row;
          result_o.status       = bmp24sp_pkg::ST_PIXEL;
          if (!(last_col && last_row)) begin
            if (last_col) begin
              col_d = '0;
              row_d = row_inc[CntW-1:0];
              pad_d = width_c[1:0];
            end else begin
              col_d = col_inc[CntW-1:0];
            end
          end
        end
      end
      default: result_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bmp24sp_pkg::PH_IDLE;
      pos_q     <= '0;
      offset_q  <= '0;
      width_q   <= '0;
      height_q  <= '0;
      scratch_q <= '0;
      blue_q    <= '0;
      green_q   <= '0;
      bip_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      pad_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      offset_q  <= offset_d;
      width_q   <= width_d;
      height_q  <= height_d;
      scratch_q <= scratch_d;
      blue_q    <= blue_d;
      green_q   <= green_d;
      bip_q     <= bip_d;
      col_q     <= col_d;
      row_q     <= row_d;
      pad_q     <= pad_d;
    end
  end

  // the column counter never runs past the image width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == bmp24sp_pkg::PH_PIXELS |-> ({1'b0, col_q} < width_q[CntW:0]))
    else $error("column count beyond image width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !start_of_file_i &&
    (phase_q == bmp24sp_pkg::PH_DONE || phase_q == bmp24sp_pkg::PH_ERROR ||
     phase_q == bmp24sp_pkg::PH_IDLE) |-> !result_o.valid)
    else $error("result produced outside an active parse");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.valid && result_o.status != bmp24sp_pkg::ST_PIXEL
    |=> phase_q == bmp24sp_pkg::PH_ERROR)
    else $error("error result did not stop the parse");

endmodule

// ===== sv/bmp24_stream_parser.sv =====
// channel | valid      | stall       | payload
// --------+------------+-------------+-------------------------------------------------
// in      | in_valid_i | in_stall_o  | data_byte_i, start_of_file_i
// out     | out_valid_o| out_stall_i | blue_o, green_o, red_o, row_index_o,
//         |            |             | column_index_o, last_pixel_o, status_o
//
// one byte per cycle while in_stall_o is low; a taken byte reaches the output through
// the input register, then the result register
// in_stall_o rises only while the held byte makes a result and the result register
// holds a beat that out_stall_i keeps
// reset leaves the parser idle; bytes are ignored until one carries start_of_file_i
module bmp24_stream_parser #(
  parameter int unsigned MAX_DIMENSION = bmp24sp_pkg::MAX_DIMENSION_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  blue_o,
  output logic [7:0]  green_o,
  output logic [7:0]  red_o,
  output logic [11:0] row_index_o,
  output logic [11:0] column_index_o,
  output logic        last_pixel_o,
  output logic [1:0]  status_o
);

  logic                 s1_valid_q, s1_valid_d;
  logic [7:0]           s1_byte_q;
  logic                 s1_start_q;
  logic                 s1_fire;
  logic                 in_accept;
  logic                 out_free;
  bmp24sp_pkg::result_t res;
  bmp24sp_pkg::result_t out_q;
  logic                 out_valid_q, out_valid_d;

  bmp24sp_core #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (s1_fire),
    .data_byte_i    (s1_byte_q),
    .start_of_file_i(s1_start_q),
    .result_o       (res)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  // a byte that makes no result never waits for the output side
  assign s1_fire     = s1_valid_q && (out_free || !res.valid);
  assign in_stall_o  = s1_valid_q && !s1_fire;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_fire);
  assign out_valid_d = (s1_fire && res.valid) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= start_of_file_i;
    end
    if (s1_fire && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blue_o         = out_q.blue;
  assign green_o        = out_q.green;
  assign red_o          = out_q.red;
  assign row_index_o    = out_q.row_index;
  assign column_index_o = out_q.column_index;
  assign last_pixel_o   = out_q.last_pixel;
  assign status_o       = out_q.status;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && res.valid && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && res.valid |=> out_valid_q)
    else $error("result lost on its way to the output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bmp24sp_pkg::ST_PIXEL |->
      blue_o == 8'd0 && green_o == 8'd0 && red_o == 8'd0 &&
      row_index_o == 12'd0 && column_index_o == 12'd0 && !last_pixel_o)
    else $error("error beat carries pixel data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> status_o == bmp24sp_pkg::ST_PIXEL)
    else $error("last pixel flag on an error beat");

endmodule
